FILE: sv/prq_pkg.sv
// shared types, widths and helpers for the plane rotation pipeline
package prq_pkg;

  localparam int Q_W        = 16;               // Q2.14 component
  localparam int DIST_W     = 32;               // Q16.16 distance
  localparam int QPROD_W    = 2 * Q_W;          // Q4.28 product
  localparam int MAT_W      = QPROD_W + 3;      // doubled products and their sums
  localparam int TERM_W     = MAT_W + Q_W;      // matrix term times normal
  localparam int ACC_W      = TERM_W + 2;       // sum of three terms
  localparam int FRAC_SHIFT = 28;               // Q*.42 down to Q*.14
  localparam int RND_W      = ACC_W - FRAC_SHIFT;
  localparam int STAGES     = 5;

  typedef logic signed [Q_W-1:0]     qval_t;
  typedef logic signed [DIST_W-1:0]  dist_t;
  typedef logic signed [QPROD_W-1:0] qprod_t;
  typedef logic signed [MAT_W-1:0]   mat_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [RND_W-1:0]   rnd_t;

  localparam mat_t MAT_ONE  = mat_t'(64'sd1 <<< FRAC_SHIFT);
  localparam acc_t RND_HALF = acc_t'(64'sd1 <<< (FRAC_SHIFT - 1));
  localparam rnd_t SAT_MAX  = rnd_t'((64'sd1 <<< (Q_W - 1)) - 64'sd1);
  localparam rnd_t SAT_MIN  = rnd_t'(-(64'sd1 <<< (Q_W - 1)));

  // doubled quaternion product, sign extended to matrix width
  function automatic mat_t dbl(input qprod_t p);
    mat_t e;
    e = mat_t'(p);
    return e <<< 1;
  endfunction

  // floor shift of a pre-biased sum, then clamp to 16 bits
  function automatic qval_t round_sat(input acc_t a);
    rnd_t q;
    q = rnd_t'(a >>> FRAC_SHIFT);
    if (q > SAT_MAX) begin
      q = SAT_MAX;
    end else if (q < SAT_MIN) begin
      q = SAT_MIN;
    end
    return qval_t'(q);
  endfunction

endpackage

FILE: sv/plane_rotate_by_quaternion.sv
// plane rotation by a quaternion: five stage streaming pipeline
//
// Rotates a plane normal (signed Q2.14) by the rotation matrix of a quaternion
// (signed Q2.14, not normalized) and passes the Q16.16 plane distance through.
// One request is taken per clock unless the output stalls, and each result passes
// in order through (stage 1 quaternion products, stage 2 matrix terms, stage 3 term-by-normal
// products, stage 4 row sums with rounding bias, stage 5 floor, clamp and
// output register). Every stage has its own valid bit and takes new data when
// it is empty or when the stage after it moves, so a stall on the output
// backs up only as far as needed and no request is dropped or repeated.
// Rounding is to nearest with ties toward plus infinity, then each rotated
// component is saturated to the 16-bit range. No state beyond the pipeline.
module plane_rotate_by_quaternion
  import prq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  qval_t quat_w,
  input  qval_t quat_x,
  input  qval_t quat_y,
  input  qval_t quat_z,
  input  qval_t normal_x,
  input  qval_t normal_y,
  input  qval_t normal_z,
  input  dist_t plane_dist,
  output logic  out_valid,
  input  logic  out_ready,
  output qval_t rot_normal_x,
  output qval_t rot_normal_y,
  output qval_t rot_normal_z,
  output dist_t out_dist
);

  // per-stage valid and load enable
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  // stage 1: the nine quaternion products
  qprod_t p_wx, p_wy, p_wz, p_xx, p_xy, p_xz, p_yy, p_yz, p_zz;
  qval_t  n1 [3];
  dist_t  dist1;

  // stage 2: rotation matrix, Q*.28
  mat_t   mat_next [3][3];
  mat_t   mat [3][3];
  qval_t  n2 [3];
  dist_t  dist2;

  // stage 3: matrix term times normal component, Q*.42
  term_t  term [3][3];
  dist_t  dist3;

  // stage 4: row sums with half an lsb of bias
  acc_t   acc [3];
  dist_t  dist4;

  // enable chain: a stage loads when empty or when its successor moves
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_wx  <= qprod_t'(quat_w) * qprod_t'(quat_x);
      p_wy  <= qprod_t'(quat_w) * qprod_t'(quat_y);
      p_wz  <= qprod_t'(quat_w) * qprod_t'(quat_z);
      p_xx  <= qprod_t'(quat_x) * qprod_t'(quat_x);
      p_xy  <= qprod_t'(quat_x) * qprod_t'(quat_y);
      p_xz  <= qprod_t'(quat_x) * qprod_t'(quat_z);
      p_yy  <= qprod_t'(quat_y) * qprod_t'(quat_y);
      p_yz  <= qprod_t'(quat_y) * qprod_t'(quat_z);
      p_zz  <= qprod_t'(quat_z) * qprod_t'(quat_z);
      n1[0] <= normal_x;
      n1[1] <= normal_y;
      n1[2] <= normal_z;
      dist1 <= plane_dist;
    end
  end

  // matrix terms from doubled products
  always_comb begin
    mat_next[0][0] = MAT_ONE - dbl(p_yy) - dbl(p_zz);
    mat_next[0][1] = dbl(p_xy) - dbl(p_wz);
    mat_next[0][2] = dbl(p_xz) + dbl(p_wy);
    mat_next[1][0] = dbl(p_xy) + dbl(p_wz);
    mat_next[1][1] = MAT_ONE - dbl(p_xx) - dbl(p_zz);
    mat_next[1][2] = dbl(p_yz) - dbl(p_wx);
    mat_next[2][0] = dbl(p_xz) - dbl(p_wy);
    mat_next[2][1] = dbl(p_yz) + dbl(p_wx);
    mat_next[2][2] = MAT_ONE - dbl(p_xx) - dbl(p_yy);
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (en[1]) begin
      mat   <= mat_next;
      n2    <= n1;
      dist2 <= dist1;
    end
  end

  // stage 3: nine 16 by 35 bit products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          term[r][c] <= term_t'(mat[r][c]) * term_t'(n2[c]);
        end
      end
      dist3 <= dist2;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        acc[r] <= acc_t'(term[r][0]) + acc_t'(term[r][1]) + acc_t'(term[r][2]) + RND_HALF;
      end
      dist4 <= dist3;
    end
  end

  // stage 5: floor, clamp, output register
  always_ff @(posedge clk) begin
    if (en[4]) begin
      rot_normal_x <= round_sat(acc[0]);
      rot_normal_y <= round_sat(acc[1]);
      rot_normal_z <= round_sat(acc[2]);
      out_dist     <= dist4;
    end
  end

  // an empty first stage always takes a request
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> in_ready)
    else $error("first stage empty but request refused");

  // a held row-sum stage keeps its item, its first row sum and its distance
  a_stage4_holds: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !en[3] |=> vld[3] && $stable(acc[0]) && $stable(dist4))
    else $error("stalled row-sum stage lost or changed its item");

  // an item in the row-sum stage moves to the output when allowed
  a_stage4_moves: assert property (@(posedge clk) disable iff (rst)
    vld[3] && en[4] |=> out_valid && out_dist == $past(dist4))
    else $error("row-sum item did not reach the output");

  // a new result only ever comes from the stage before it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld[3]))
    else $error("output valid without an item behind it");

endmodule
